@@ hw/rtl/radar_vital_frame_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// radar_vital_frame_parser_unit_assert.svh
// assertion macros used by the frame parser top-level rtl
// ----------------------------------------------------------------------------
`ifndef RADAR_VITAL_FRAME_PARSER_UNIT_ASSERT_SVH
`define RADAR_VITAL_FRAME_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RVFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// next-cycle implication, disabled during reset
`define RVFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

@@ hw/rtl/rvfp_pkg.sv @@
// ----------------------------------------------------------------------------
// rvfp_pkg
// types, codes and constants of the vital radar frame parser
// ----------------------------------------------------------------------------
package rvfp_pkg;

  // frame delimiters
  localparam logic [7:0] START1_BYTE = 8'h53;
  localparam logic [7:0] START2_BYTE = 8'h59;
  localparam logic [7:0] END1_BYTE   = 8'h54;
  localparam logic [7:0] END2_BYTE   = 8'h43;

  // frame types and commands
  localparam logic [7:0] KIND_STATUS = 8'h05;
  localparam logic [7:0] KIND_BREATH = 8'h80;
  localparam logic [7:0] KIND_HEART  = 8'h81;
  localparam logic [7:0] OP_CATEGORY = 8'h01;
  localparam logic [7:0] OP_WAVE     = 8'h02;
  localparam logic [7:0] OP_RATE     = 8'h05;

  // configuration register indexes
  localparam logic CFG_MAX_LEN   = 1'b0;
  localparam logic CFG_MEAS_CODE = 1'b1;

  // reset values
  localparam logic [15:0] DEFAULT_MAX_LEN   = 16'd60;
  localparam logic [7:0]  DEFAULT_MEAS_CODE = 8'h00;
  localparam logic [8:0]  RATE_UNKNOWN      = 9'h1FF;
  localparam int          DEFAULT_COUNTER_WIDTH = 32;

  // payload bytes that a decision can ever look at
  localparam int HEAD_BYTES = 4;

  typedef enum logic [3:0] {
    PH_START1, PH_START2, PH_KIND, PH_CMD, PH_LEN_LO,
    PH_LEN_HI, PH_PAYLOAD, PH_SUM, PH_END1, PH_END2
  } phase_t;

  typedef enum logic [1:0] {
    OUT_GOOD, OUT_TOO_LONG, OUT_BAD_SUM, OUT_BAD_END
  } outcome_t;

  // end of frame, parser to value store
  typedef struct packed {
    logic        valid;
    outcome_t    outcome;
    logic [7:0]  kind;
    logic [7:0]  cmd;
    logic        len_ge1;
    logic        len_ge4;
    logic [31:0] head;
  } frame_evt_t;

endpackage

@@ hw/rtl/rvfp_parser.sv @@
// ----------------------------------------------------------------------------
// rvfp_parser
// byte-level frame state machine: header, length check, payload, end bytes and checksum
// ----------------------------------------------------------------------------
module rvfp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         data,
  input  logic [15:0]        max_len,
  output rvfp_pkg::frame_evt_t evt
);
  import rvfp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  kind, kind_next;
  logic [7:0]  cmd, cmd_next;
  logic [15:0] length, length_next;
  logic [15:0] count, count_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  head [HEAD_BYTES];
  logic        head_we;
  logic [15:0] full_len;
  logic [15:0] count_inc;
  logic        evt_valid;
  outcome_t    evt_outcome;

  assign full_len  = {data, length[7:0]};
  assign count_inc = count + 16'd1;

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_START1:  if (data == START1_BYTE) phase_next = PH_START2;
      PH_START2:  phase_next = (data == START2_BYTE) ? PH_KIND : PH_START1;
      PH_KIND:    phase_next = PH_CMD;
      PH_CMD:     phase_next = PH_LEN_LO;
      PH_LEN_LO:  phase_next = PH_LEN_HI;
      PH_LEN_HI: begin
        if (full_len == 16'd0)         phase_next = PH_SUM;
        else if (full_len > max_len)   phase_next = PH_START1;
        else                           phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: if (count_inc == length) phase_next = PH_SUM;
      PH_SUM:     phase_next = (data == sum) ? PH_END1 : PH_START1;
      PH_END1:    phase_next = (data == END1_BYTE) ? PH_END2 : PH_START1;
      PH_END2:    phase_next = PH_START1;
      default:    phase_next = PH_START1;
    endcase
  end

  // field capture, checksum and end-of-frame event
  always_comb begin
    kind_next   = kind;
    cmd_next    = cmd;
    length_next = length;
    count_next  = count;
    sum_next    = sum;
    head_we     = 1'b0;
    evt_valid   = 1'b0;
    evt_outcome = OUT_GOOD;
    unique case (phase)
      PH_KIND: begin
        kind_next = data;
        sum_next  = data;
      end
      PH_CMD: begin
        cmd_next = data;
        sum_next = sum + data;
      end
      PH_LEN_LO: begin
        length_next = {8'h00, data};
        sum_next    = sum + data;
      end
      PH_LEN_HI: begin
        length_next = full_len;
        sum_next    = sum + data;
        count_next  = 16'd0;
        if (full_len != 16'd0 && full_len > max_len) begin
          evt_valid   = 1'b1;
          evt_outcome = OUT_TOO_LONG;
        end
      end
      PH_PAYLOAD: begin
        head_we    = (count < 16'(HEAD_BYTES));
        count_next = count_inc;
        sum_next   = sum + data;
      end
      PH_SUM: begin
        if (data != sum) begin
          evt_valid   = 1'b1;
          evt_outcome = OUT_BAD_SUM;
        end
      end
      PH_END2: begin
        evt_valid   = 1'b1;
        evt_outcome = (data == END2_BYTE) ? OUT_GOOD : OUT_BAD_END;
      end
      default: ;
    endcase
  end

  // event fields in struct order
  assign evt = {evt_valid, evt_outcome, kind, cmd, (length != 16'd0),
                (length >= 16'd4), head[3], head[2], head[1], head[0]};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_START1;
      kind   <= '0;
      cmd    <= '0;
      length <= '0;
      count  <= '0;
      sum    <= '0;
    end else if (fire) begin
      phase  <= phase_next;
      kind   <= kind_next;
      cmd    <= cmd_next;
      length <= length_next;
      count  <= count_next;
      sum    <= sum_next;
    end
  end

  // first payload bytes, undefined until written
  always_ff @(posedge clk) begin
    if (fire && head_we) begin
      head[count[$clog2(HEAD_BYTES)-1:0]] <= data;
    end
  end

endmodule

@@ hw/rtl/rvfp_store.sv @@
// ----------------------------------------------------------------------------
// rvfp_store
// reported values, change detection and frame counters
// ----------------------------------------------------------------------------
module rvfp_store #(
  parameter int COUNTER_WIDTH = rvfp_pkg::DEFAULT_COUNTER_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  rvfp_pkg::frame_evt_t evt,
  input  logic [7:0]           meas_code,
  output logic                 changed,
  output logic [7:0]           presence_status,
  output logic signed [8:0]    breath_rate,
  output logic [7:0]           breath_category,
  output logic [31:0]          breath_wave_bits,
  output logic signed [8:0]    heart_rate,
  output logic [7:0]           heart_category,
  output logic [31:0]          heart_wave_bits,
  output logic [31:0]          good_frame_count,
  output logic [31:0]          bad_frame_count,
  output logic                 sensor_ready
);
  import rvfp_pkg::*;

  logic [7:0]  status, status_next;
  logic [8:0]  br_rate, br_rate_next, hr_rate, hr_rate_next;
  logic [7:0]  br_cat, br_cat_next, hr_cat, hr_cat_next;
  logic [31:0] br_wave, br_wave_next, hr_wave, hr_wave_next;
  logic [COUNTER_WIDTH-1:0] good_cnt, bad_cnt;
  logic        good_end, bad_end;
  logic        is_breath;
  logic [7:0]  d0;
  logic [8:0]  old_rate;
  logic [7:0]  old_cat;
  logic [31:0] old_wave;
  logic        wave_diff;

  function automatic logic is_nan(input logic [31:0] w);
    is_nan = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
  endfunction

  assign good_end  = evt.valid && (evt.outcome == OUT_GOOD);
  assign bad_end   = evt.valid && (evt.outcome != OUT_GOOD);
  assign is_breath = (evt.kind == KIND_BREATH);
  assign d0        = evt.head[7:0];
  assign old_rate  = is_breath ? br_rate : hr_rate;
  assign old_cat   = is_breath ? br_cat : hr_cat;
  assign old_wave  = is_breath ? br_wave : hr_wave;

  // float inequality: nan always differs, signed zeros are equal
  always_comb begin
    if (is_nan(evt.head) || is_nan(old_wave))          wave_diff = 1'b1;
    else if (((evt.head | old_wave) & 32'h7FFF_FFFF) == 32'd0) wave_diff = 1'b0;
    else                                               wave_diff = (evt.head != old_wave);
  end

  // value update for a good frame
  always_comb begin
    status_next  = status;
    br_rate_next = br_rate;
    hr_rate_next = hr_rate;
    br_cat_next  = br_cat;
    hr_cat_next  = hr_cat;
    br_wave_next = br_wave;
    hr_wave_next = hr_wave;
    changed      = 1'b0;
    if (good_end) begin
      if (evt.kind == KIND_STATUS) begin
        if (evt.cmd == OP_CATEGORY && evt.len_ge1 && status != d0) begin
          status_next = d0;
          changed     = 1'b1;
        end
      end else if (evt.kind == KIND_BREATH || evt.kind == KIND_HEART) begin
        if (evt.cmd == OP_CATEGORY && evt.len_ge1) begin
          if (old_cat != d0) begin
            changed = 1'b1;
            if (is_breath) br_cat_next = d0;
            else           hr_cat_next = d0;
          end
        end else if (evt.cmd == OP_RATE && evt.len_ge1) begin
          if (old_rate != {1'b0, d0}) begin
            changed = 1'b1;
            if (is_breath) br_rate_next = {1'b0, d0};
            else           hr_rate_next = {1'b0, d0};
          end
        end else if (evt.cmd == OP_WAVE && evt.len_ge4) begin
          if (wave_diff) begin
            changed = 1'b1;
            if (is_breath) br_wave_next = evt.head;
            else           hr_wave_next = evt.head;
          end
        end
      end
    end
  end

  // stored values and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      status   <= '0;
      br_rate  <= RATE_UNKNOWN;
      hr_rate  <= RATE_UNKNOWN;
      br_cat   <= '0;
      hr_cat   <= '0;
      br_wave  <= '0;
      hr_wave  <= '0;
      good_cnt <= '0;
      bad_cnt  <= '0;
    end else if (fire) begin
      status  <= status_next;
      br_rate <= br_rate_next;
      hr_rate <= hr_rate_next;
      br_cat  <= br_cat_next;
      hr_cat  <= hr_cat_next;
      br_wave <= br_wave_next;
      hr_wave <= hr_wave_next;
      if (good_end) good_cnt <= good_cnt + COUNTER_WIDTH'(1);
      if (bad_end)  bad_cnt  <= bad_cnt + COUNTER_WIDTH'(1);
    end
  end

  // counter view on the 32-bit ports
  generate
    if (COUNTER_WIDTH >= 32) begin : g_cnt_trunc
      assign good_frame_count = good_cnt[31:0];
      assign bad_frame_count  = bad_cnt[31:0];
    end else begin : g_cnt_ext
      assign good_frame_count = {{(32-COUNTER_WIDTH){1'b0}}, good_cnt};
      assign bad_frame_count  = {{(32-COUNTER_WIDTH){1'b0}}, bad_cnt};
    end
  endgenerate

  assign presence_status  = status;
  assign breath_rate      = br_rate;
  assign heart_rate       = hr_rate;
  assign breath_category  = br_cat;
  assign heart_category   = hr_cat;
  assign breath_wave_bits = br_wave;
  assign heart_wave_bits  = hr_wave;

  // ready when measuring and both rates above zero
  assign sensor_ready = (status == meas_code)
                     && !br_rate[8] && (br_rate[7:0] != 8'd0)
                     && !hr_rate[8] && (hr_rate[7:0] != 8'd0);

endmodule

@@ hw/rtl/radar_vital_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// radar_vital_frame_parser_unit
// byte-serial frame parser for a vital-sign radar link
// ----------------------------------------------------------------------------
// Received bytes enter on the in_valid/in_ready channel, one byte per
// transaction. Every frame that ends (good, too long, bad checksum, bad final
// end byte) gives one transaction on the out_valid/out_ready channel; bytes
// that only advance the parser, and silent resyncs, give none.
// A byte is held in an input register and is parsed once the result slot is
// free, which also loads the result register, so out_valid rises when the
// last byte of a frame has passed the input and result registers.
// Throughput is one byte per cycle while the receiver takes results.
// The stored values and counters on the result ports are the live value
// registers; they cannot move while a result waits, since parsing halts then.
// When out_ready is low with a result pending, the parser stops, the input
// register holds one byte and in_ready drops once it is full.
// cfg_write_en writes max_payload_len (index 0) or measuring_status_code
// (index 1); write only while no frame is in flight.
// Synchronous reset returns the parser to the start-byte search, clears the
// counters and values, sets both rates to -1 and max_payload_len to 60.
// ----------------------------------------------------------------------------
module radar_vital_frame_parser_unit #(
  parameter int COUNTER_WIDTH = rvfp_pkg::DEFAULT_COUNTER_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        frame_outcome,
  output logic              values_changed,
  output logic [7:0]        presence_status,
  output logic signed [8:0] breath_rate,
  output logic [7:0]        breath_category,
  output logic [31:0]       breath_wave_bits,
  output logic signed [8:0] heart_rate,
  output logic [7:0]        heart_category,
  output logic [31:0]       heart_wave_bits,
  output logic [31:0]       good_frame_count,
  output logic [31:0]       bad_frame_count,
  output logic              sensor_ready,
  input  logic              cfg_write_en,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);
  import rvfp_pkg::*;
  `include "radar_vital_frame_parser_unit_assert.svh"

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       fire;
  logic       res_valid;
  outcome_t   res_outcome;
  logic       res_changed;
  logic       changed;
  logic [15:0] max_payload_len;
  logic [7:0]  meas_code;
  frame_evt_t  evt;

  // parse the held byte when the result slot is free or being emptied
  assign fire     = in_reg_valid && (!res_valid || out_ready);
  assign in_ready = !in_reg_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_byte <= rx_byte;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= DEFAULT_MAX_LEN;
      meas_code       <= DEFAULT_MEAS_CODE;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_MAX_LEN:   max_payload_len <= cfg_data;
        CFG_MEAS_CODE: meas_code       <= cfg_data[7:0];
      endcase
    end
  end

  rvfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .data    (in_reg_byte),
    .max_len (max_payload_len),
    .evt     (evt)
  );

  rvfp_store #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_store (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .evt              (evt),
    .meas_code        (meas_code),
    .changed          (changed),
    .presence_status  (presence_status),
    .breath_rate      (breath_rate),
    .breath_category  (breath_category),
    .breath_wave_bits (breath_wave_bits),
    .heart_rate       (heart_rate),
    .heart_category   (heart_category),
    .heart_wave_bits  (heart_wave_bits),
    .good_frame_count (good_frame_count),
    .bad_frame_count  (bad_frame_count),
    .sensor_ready     (sensor_ready)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && evt.valid) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && evt.valid) begin
      res_outcome <= evt.outcome;
      res_changed <= changed;
    end
  end

  assign out_valid      = res_valid;
  assign frame_outcome  = res_outcome;
  assign values_changed = res_changed;

  // checks
  `RVFP_ASSERT_NEXT(a_stall_freezes_counts, clk, rst, out_valid && !out_ready,
    $stable(good_frame_count) && $stable(bad_frame_count))
  `RVFP_ASSERT_NOW(a_changed_only_good, clk, rst, out_valid && values_changed,
    frame_outcome == OUT_GOOD)
  `RVFP_ASSERT_NOW(a_backpressure_cause, clk, rst, !in_ready,
    in_reg_valid && res_valid && !out_ready)

endmodule
